[src/card_slot_mount_state_machine_defines.svh]
// Assertion macros for the card slot mount block.
// Each expects clk and rst_n in scope at the place of use.
`ifndef CARD_SLOT_MOUNT_STATE_MACHINE_DEFINES_SVH
`define CARD_SLOT_MOUNT_STATE_MACHINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CSM_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CSM_ASSERT_CLK(lbl, prop, msg)
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/csm_pkg.sv]
`default_nettype none
package csm_pkg;

  localparam logic [3:0] ST_INIT_EMPTY  = 4'd0;
  localparam logic [3:0] ST_INIT_UNMNT  = 4'd1;
  localparam logic [3:0] ST_INIT_MNT    = 4'd2;
  localparam logic [3:0] ST_OPEN_EMPTY  = 4'd3;
  localparam logic [3:0] ST_OPEN_UNMNT  = 4'd4;
  localparam logic [3:0] ST_OPEN_MNT    = 4'd5;
  localparam logic [3:0] ST_CLOSE_EMPTY = 4'd6;
  localparam logic [3:0] ST_CLOSE_UNMNT = 4'd7;
  localparam logic [3:0] ST_CLOSE_MNT   = 4'd8;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_MOUNT = 3'd1;
  localparam logic [2:0] CMD_LAZY  = 3'd2;
  localparam logic [2:0] CMD_FORCE = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;

  localparam logic [1:0] NOTE_NONE    = 2'd0;
  localparam logic [1:0] NOTE_MOUNTED = 2'd1;
  localparam logic [1:0] NOTE_UNMOUNT = 2'd2;

  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_OPEN    = 3'd1;
  localparam logic [2:0] ACT_CLOSE   = 3'd2;
  localparam logic [2:0] ACT_ADDED   = 3'd3;
  localparam logic [2:0] ACT_REMOVED = 3'd4;
  localparam logic [2:0] ACT_DONE    = 3'd5;
  localparam logic [2:0] ACT_RETRY   = 3'd6;

  localparam logic [1:0] MSTAT_UNMOUNTED = 2'd0;
  localparam logic [1:0] MSTAT_MOUNTED   = 2'd1;

  localparam logic [7:0] RETRY_LIMIT_RESET = 8'd100;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] mount_status;
    logic       device_present;
    logic       command_ok;
  } csm_in_t;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] notice;
    logic [3:0] slot_state;
    logic       timed_out;
  } csm_out_t;

  typedef struct packed {
    logic [3:0] cur;
    logic [3:0] succ;
    logic [3:0] fail;
    logic [7:0] wait_cnt;
    logic       waiting;
    logic       last_mount;
    logic       busy;
  } csm_state_t;

endpackage
`default_nettype wire

[src/card_slot_mount_state_machine.sv]
// Card slot mount controller.
// Input channel (in_valid/in_ready/in_data) carries one slot event per beat:
// init probe, door open/close, card added/removed, command done, retry tick.
// Result channel (out_valid/out_ready/out_data) returns exactly one beat per
// event: the command to run, an announcement, the slot state after the event
// and a timeout flag for a mount that gave up waiting for the device.
// cfg_wr_en/cfg_wr_data write retry_limit (reset 100); write only while idle.
// An accepted event is held in the input register; the state update then
// writes its result into the result register, which drives out_valid.
// Throughput: one event per cycle while the result is taken; the state
// update is a single pass of logic between the input and result registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more event; in_ready then drops until the result
// is taken. rst_n (synchronous) returns the slot to init empty with no
// command outstanding, no device wait pending and both channels empty.
`default_nettype none
`include "card_slot_mount_state_machine_defines.svh"
module card_slot_mount_state_machine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csm_pkg::csm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output csm_pkg::csm_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  logic                stg_v_r;
  csm_pkg::csm_in_t    stg_item_r;
  logic                out_v_r;
  csm_pkg::csm_out_t   out_data_r;
  csm_pkg::csm_state_t st_r;
  csm_pkg::csm_state_t st_nxt;
  csm_pkg::csm_out_t   res;
  logic [7:0]          retry_limit_r;
  logic                advance;

  assign advance   = stg_v_r && (!out_v_r || out_ready);
  assign in_ready  = !stg_v_r || advance;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  csm_step u_step (
    .st          (st_r),
    .item        (stg_item_r),
    .retry_limit (retry_limit_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r       <= 1'b0;
      out_v_r       <= 1'b0;
      retry_limit_r <= csm_pkg::RETRY_LIMIT_RESET;
      st_r.cur        <= csm_pkg::ST_INIT_EMPTY;
      st_r.succ       <= csm_pkg::ST_INIT_EMPTY;
      st_r.fail       <= csm_pkg::ST_INIT_EMPTY;
      st_r.wait_cnt   <= '0;
      st_r.waiting    <= 1'b0;
      st_r.last_mount <= 1'b0;
      st_r.busy       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        retry_limit_r <= cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        stg_v_r    <= 1'b1;
        stg_item_r <= in_data;
      end else if (advance) begin
        stg_v_r <= 1'b0;
      end
      // Advance the staged beat into the result register and commit state.
      if (advance) begin
        out_v_r    <= 1'b1;
        out_data_r <= res;
        st_r       <= st_nxt;
      end else if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  `CSM_ASSERT_CLK(a_wait_idle_zero, !st_r.waiting |-> st_r.wait_cnt == 8'd0, "wait count set with no wait pending")
  `CSM_ASSERT_CLK(a_state_range, st_r.cur <= csm_pkg::ST_CLOSE_MNT, "slot state out of range")
  `CSM_ASSERT_CLK(a_tmo_no_cmd, out_v_r && out_data_r.timed_out |-> out_data_r.command == csm_pkg::CMD_NONE, "timeout beat carries a command")
  `CSM_ASSERT_CLK(a_full_blocks, stg_v_r && out_v_r && !out_ready |-> !in_ready, "input taken with both stages full")
  `CSM_ASSERT_NEXT(a_stage_hold, stg_v_r && !advance, stg_v_r && $stable(stg_item_r), "staged beat lost while blocked")

endmodule
`default_nettype wire

[src/csm_step.sv]
`default_nettype none
module csm_step (
  input  csm_pkg::csm_state_t st,
  input  csm_pkg::csm_in_t    item,
  input  logic [7:0]          retry_limit,
  output csm_pkg::csm_state_t st_nxt,
  output csm_pkg::csm_out_t   res
);

  csm_pkg::csm_state_t ms_st;
  logic [2:0]          ms_cmd;
  logic                ms_tmo;

  // Mount attempt from the current state with the new targets applied later.
  always_comb begin
    ms_st  = st;
    ms_cmd = csm_pkg::CMD_NONE;
    ms_tmo = 1'b0;
    if (st.wait_cnt >= retry_limit) begin
      ms_st.wait_cnt = '0;
      ms_st.waiting  = 1'b0;
      ms_tmo         = 1'b1;
    end else if (!item.device_present) begin
      ms_st.wait_cnt = st.wait_cnt + 8'd1;
      ms_st.waiting  = 1'b1;
      ms_cmd         = csm_pkg::CMD_WAIT;
    end else begin
      ms_st.wait_cnt   = '0;
      ms_st.waiting    = 1'b0;
      ms_st.last_mount = 1'b1;
      ms_st.busy       = 1'b1;
      ms_cmd           = csm_pkg::CMD_MOUNT;
    end
  end

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (item.action)
      csm_pkg::ACT_INIT: begin
        if (item.mount_status == csm_pkg::MSTAT_UNMOUNTED) begin
          st_nxt.cur = item.device_present ? csm_pkg::ST_INIT_UNMNT : csm_pkg::ST_INIT_EMPTY;
        end else if (item.mount_status == csm_pkg::MSTAT_MOUNTED) begin
          st_nxt.cur = csm_pkg::ST_INIT_MNT;
          res.notice = csm_pkg::NOTE_MOUNTED;
        end
      end
      csm_pkg::ACT_OPEN: begin
        if (st.cur inside {csm_pkg::ST_CLOSE_MNT, csm_pkg::ST_INIT_MNT}) begin
          st_nxt.cur        = csm_pkg::ST_OPEN_MNT;
          st_nxt.succ       = csm_pkg::ST_OPEN_UNMNT;
          st_nxt.fail       = csm_pkg::ST_OPEN_MNT;
          st_nxt.last_mount = 1'b0;
          st_nxt.busy       = 1'b1;
          res.command       = csm_pkg::CMD_LAZY;
          res.notice        = csm_pkg::NOTE_UNMOUNT;
        end else if (st.cur inside {csm_pkg::ST_INIT_UNMNT, csm_pkg::ST_CLOSE_UNMNT}) begin
          st_nxt.cur = csm_pkg::ST_OPEN_UNMNT;
        end else if (st.cur inside {csm_pkg::ST_CLOSE_EMPTY, csm_pkg::ST_INIT_EMPTY}) begin
          st_nxt.cur = csm_pkg::ST_OPEN_EMPTY;
        end
      end
      csm_pkg::ACT_CLOSE: begin
        if (st.cur inside {csm_pkg::ST_OPEN_UNMNT, csm_pkg::ST_INIT_UNMNT}) begin
          st_nxt      = ms_st;
          st_nxt.succ = csm_pkg::ST_CLOSE_MNT;
          st_nxt.fail = csm_pkg::ST_CLOSE_UNMNT;
          if (ms_tmo) begin
            st_nxt.cur = csm_pkg::ST_CLOSE_UNMNT;
          end
          res.command   = ms_cmd;
          res.timed_out = ms_tmo;
        end else if (st.cur inside {csm_pkg::ST_OPEN_EMPTY, csm_pkg::ST_INIT_EMPTY}) begin
          st_nxt.cur = csm_pkg::ST_CLOSE_EMPTY;
        end else if (st.cur inside {csm_pkg::ST_INIT_MNT, csm_pkg::ST_OPEN_MNT}) begin
          st_nxt.cur = csm_pkg::ST_CLOSE_MNT;
        end
      end
      csm_pkg::ACT_ADDED: begin
        if (st.cur inside {csm_pkg::ST_CLOSE_EMPTY, csm_pkg::ST_OPEN_EMPTY}) begin
          st_nxt      = ms_st;
          st_nxt.succ = csm_pkg::ST_CLOSE_MNT;
          st_nxt.fail = csm_pkg::ST_CLOSE_UNMNT;
          if (ms_tmo) begin
            st_nxt.cur = csm_pkg::ST_CLOSE_UNMNT;
          end
          res.command   = ms_cmd;
          res.timed_out = ms_tmo;
        end
      end
      csm_pkg::ACT_REMOVED: begin
        if (st.cur == csm_pkg::ST_OPEN_UNMNT) begin
          st_nxt.cur = csm_pkg::ST_OPEN_EMPTY;
        end else if (st.cur == csm_pkg::ST_OPEN_MNT) begin
          st_nxt.succ       = csm_pkg::ST_OPEN_EMPTY;
          st_nxt.fail       = csm_pkg::ST_OPEN_EMPTY;
          st_nxt.last_mount = 1'b0;
          st_nxt.busy       = 1'b1;
          res.command       = csm_pkg::CMD_FORCE;
          res.notice        = csm_pkg::NOTE_UNMOUNT;
        end
      end
      csm_pkg::ACT_DONE: begin
        if (st.busy) begin
          st_nxt.busy = 1'b0;
          st_nxt.cur  = item.command_ok ? st.succ : st.fail;
          if (item.command_ok && st.last_mount) begin
            res.notice = csm_pkg::NOTE_MOUNTED;
          end
        end
      end
      csm_pkg::ACT_RETRY: begin
        // Drop stray ticks; otherwise continue the pending mount attempt.
        if (st.waiting) begin
          st_nxt = ms_st;
          if (ms_tmo) begin
            st_nxt.cur = st.fail;
          end
          res.command   = ms_cmd;
          res.timed_out = ms_tmo;
        end
      end
      default: begin
      end
    endcase
    res.slot_state = st_nxt.cur;
  end

endmodule
`default_nettype wire

[tb/slot_event_checker.sv]
`timescale 1ns / 1ps
module slot_event_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  csm_pkg::csm_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  csm_pkg::csm_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  output int                errors,
  output int                outstanding
);
  import csm_pkg::*;

  typedef struct {
    logic [3:0] cur, ok_next, err_next;
    logic [7:0] polls;
    logic       polling;
    logic       mounting;
    logic       busy;
  } slot_model_t;

  slot_model_t slot;
  logic [7:0]  retry_limit;
  csm_out_t    expected_results[$];

  function automatic logic [2:0] mount_attempt(input logic present, output logic gave_up);
    gave_up = 1'b0;
    if (slot.polls >= retry_limit) begin
      slot.cur = slot.err_next;
      slot.polls = '0;
      slot.polling = 1'b0;
      gave_up = 1'b1;
      return CMD_NONE;
    end
    if (!present) begin
      slot.polls = slot.polls + 8'd1;
      slot.polling = 1'b1;
      return CMD_WAIT;
    end
    slot.polls = '0;
    slot.polling = 1'b0;
    slot.mounting = 1'b1;
    slot.busy = 1'b1;
    return CMD_MOUNT;
  endfunction

  function automatic logic [2:0] start_unmount(input logic forced);
    slot.mounting = 1'b0;
    slot.busy = 1'b1;
    return forced ? CMD_FORCE : CMD_LAZY;
  endfunction

  function automatic csm_out_t predict_slot_event(input csm_in_t ev);
    csm_out_t   res;
    logic [3:0] s;
    logic       gave;
    res = '0;
    gave = 1'b0;
    s = slot.cur;
    case (ev.action)
      ACT_INIT: begin
        if (ev.mount_status == MSTAT_UNMOUNTED) begin
          slot.cur = ev.device_present ? ST_INIT_UNMNT : ST_INIT_EMPTY;
        end else if (ev.mount_status == MSTAT_MOUNTED) begin
          slot.cur = ST_INIT_MNT;
          res.notice = NOTE_MOUNTED;
        end
      end
      ACT_OPEN: begin
        if (s == ST_CLOSE_MNT || s == ST_INIT_MNT) begin
          slot.cur = ST_OPEN_MNT;
          slot.ok_next = ST_OPEN_UNMNT;
          slot.err_next = ST_OPEN_MNT;
          res.command = start_unmount(1'b0);
          res.notice = NOTE_UNMOUNT;
        end else if (s == ST_INIT_UNMNT || s == ST_CLOSE_UNMNT) begin
          slot.cur = ST_OPEN_UNMNT;
        end else if (s == ST_CLOSE_EMPTY || s == ST_INIT_EMPTY) begin
          slot.cur = ST_OPEN_EMPTY;
        end
      end
      ACT_CLOSE: begin
        if (s == ST_OPEN_UNMNT || s == ST_INIT_UNMNT) begin
          slot.ok_next = ST_CLOSE_MNT;
          slot.err_next = ST_CLOSE_UNMNT;
          res.command = mount_attempt(ev.device_present, gave);
        end else if (s == ST_OPEN_EMPTY || s == ST_INIT_EMPTY) begin
          slot.cur = ST_CLOSE_EMPTY;
        end else if (s == ST_INIT_MNT || s == ST_OPEN_MNT) begin
          slot.cur = ST_CLOSE_MNT;
        end
      end
      ACT_ADDED: begin
        if (s == ST_CLOSE_EMPTY || s == ST_OPEN_EMPTY) begin
          slot.ok_next = ST_CLOSE_MNT;
          slot.err_next = ST_CLOSE_UNMNT;
          res.command = mount_attempt(ev.device_present, gave);
        end
      end
      ACT_REMOVED: begin
        if (s == ST_OPEN_UNMNT) begin
          slot.cur = ST_OPEN_EMPTY;
        end else if (s == ST_OPEN_MNT) begin
          slot.ok_next = ST_OPEN_EMPTY;
          slot.err_next = ST_OPEN_EMPTY;
          res.command = start_unmount(1'b1);
          res.notice = NOTE_UNMOUNT;
        end
      end
      ACT_DONE: begin
        // only the newest command is tracked; a stray completion is dropped
        if (slot.busy) begin
          slot.busy = 1'b0;
          slot.cur = ev.command_ok ? slot.ok_next : slot.err_next;
          if (ev.command_ok && slot.mounting) res.notice = NOTE_MOUNTED;
        end
      end
      ACT_RETRY: begin
        if (slot.polling) res.command = mount_attempt(ev.device_present, gave);
      end
      default: ;
    endcase
    res.slot_state = slot.cur;
    res.timed_out = gave;
    return res;
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    csm_out_t got, want;
    if (!rst_n) begin
      slot.cur = ST_INIT_EMPTY;
      slot.ok_next = ST_INIT_EMPTY;
      slot.err_next = ST_INIT_EMPTY;
      slot.polls = '0;
      slot.polling = 1'b0;
      slot.mounting = 1'b0;
      slot.busy = 1'b0;
      retry_limit = RETRY_LIMIT_RESET;
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) retry_limit = cfg_wr_data;
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result beat cmd %0d notice %0d state %0d tmo %0d",
                                 got.command, got.notice, got.slot_state, got.timed_out));
        end else begin
          want = expected_results.pop_front();
          if (got.command !== want.command || got.notice !== want.notice ||
              got.slot_state !== want.slot_state || got.timed_out !== want.timed_out)
            note_failure($sformatf({"result mismatch: expected cmd %0d notice %0d state %0d ",
                                    "tmo %0d, got cmd %0d notice %0d state %0d tmo %0d"},
                                   want.command, want.notice, want.slot_state, want.timed_out,
                                   got.command, got.notice, got.slot_state, got.timed_out));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_slot_event(in_data));
    end
    outstanding = expected_results.size();
  end

endmodule

[tb/tb_card_slot_mount_state_machine.sv]
`timescale 1ns / 1ps
module tb_card_slot_mount_state_machine;
  import csm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  csm_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  csm_out_t   out_data;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  int         errors;
  int         outstanding;
  int         sent = 0;
  int         idle_cycles = 0;
  int         rx_hold = 0;
  bit         steady = 1'b0;
  logic [7:0] limit_now = RETRY_LIMIT_RESET;

  always #10 clk = ~clk;

  card_slot_mount_state_machine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  slot_event_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (errors),
    .outstanding(outstanding)
  );

  // mostly short pauses, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[card_slot_mount_state_machine] ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready = 1'b0;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      out_ready = 1'b1;
    end else begin
      rx_hold = pick_gap();
      out_ready = 1'b0;
    end
  end

  // valid stays up after the beat; whoever pauses next drops it
  task automatic send_event(input logic [2:0] act, input logic [1:0] ms,
                            input logic present, input logic ok);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data.action = act;
    in_data.mount_status = ms;
    in_data.device_present = present;
    in_data.command_ok = ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_retry_limit(input logic [7:0] value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    limit_now = value;
  endtask

  task automatic mount_cycle();
    int polls;
    send_event(ACT_OPEN, 2'($urandom), 1'($urandom), 1'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_event(ACT_REMOVED, 2'($urandom), 1'($urandom), 1'($urandom));
    send_event(ACT_CLOSE, 2'($urandom), $urandom_range(0, 3) != 0, 1'($urandom));
    polls = $urandom_range(0, (limit_now < 6) ? int'(limit_now) : 6);
    repeat (polls)
      send_event(ACT_RETRY, 2'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
    send_event(ACT_DONE, 2'($urandom), 1'($urandom), $urandom_range(0, 4) != 0);
  endtask

  task automatic card_swap();
    send_event(ACT_OPEN, 2'($urandom), 1'($urandom), 1'($urandom));
    send_event(ACT_REMOVED, 2'($urandom), 1'($urandom), 1'($urandom));
    send_event(ACT_DONE, 2'($urandom), 1'($urandom), $urandom_range(0, 4) != 0);
    send_event(ACT_REMOVED, 2'($urandom), 1'($urandom), 1'($urandom));
    send_event(ACT_ADDED, 2'($urandom), 1'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 3))
      send_event(ACT_RETRY, 2'($urandom), 1'($urandom), 1'($urandom));
    send_event(ACT_DONE, 2'($urandom), 1'($urandom), $urandom_range(0, 4) != 0);
  endtask

  // run the device wait out to the retry limit so the attempt gives up
  task automatic poll_to_timeout();
    send_event(ACT_INIT, MSTAT_UNMOUNTED, 1'b1, 1'($urandom));
    send_event(ACT_CLOSE, 2'($urandom), 1'b0, 1'($urandom));
    for (int i = 0; i <= int'(limit_now); i++)
      send_event(ACT_RETRY, 2'($urandom), 1'b0, 1'($urandom));
  endtask

  task automatic random_phase(input logic [7:0] value, input int count);
    int goal;
    int kind;
    set_retry_limit(value);
    goal = sent + count;
    while (sent < goal) begin
      steady = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 7) mount_cycle();
      else if (kind < 10) card_swap();
      else if (kind < 12) send_event(ACT_INIT, 2'($urandom), 1'($urandom), 1'($urandom));
      else if (kind == 12 && (limit_now < 20 || $urandom_range(0, 3) == 0)) poll_to_timeout();
      else if (kind == 13) drain();
      else send_event(3'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_event(ACT_INIT, MSTAT_UNMOUNTED, 1'b0, 1'b0);
    send_event(3'd7, 2'd3, 1'b1, 1'b1);
    send_event(ACT_INIT, 2'd3, 1'b1, 1'b0);
    send_event(ACT_INIT, 2'd2, 1'b1, 1'b1);
    send_event(ACT_RETRY, 2'd0, 1'b1, 1'b1);
    send_event(ACT_DONE, 2'd0, 1'b0, 1'b1);
    send_event(ACT_INIT, MSTAT_MOUNTED, 1'b0, 1'b0);
    send_event(ACT_OPEN, 2'd0, 1'b0, 1'b0);
    send_event(ACT_REMOVED, 2'd0, 1'b0, 1'b0);
    send_event(ACT_DONE, 2'd0, 1'b0, 1'b1);
    send_event(ACT_ADDED, 2'd0, 1'b0, 1'b0);
    send_event(ACT_RETRY, 2'd0, 1'b0, 1'b0);
    send_event(ACT_RETRY, 2'd0, 1'b1, 1'b0);
    send_event(ACT_DONE, 2'd0, 1'b0, 1'b1);
    send_event(ACT_OPEN, 2'd0, 1'b0, 1'b0);
    send_event(ACT_DONE, 2'd0, 1'b0, 1'b0);
    send_event(ACT_CLOSE, 2'd0, 1'b0, 1'b0);
    send_event(ACT_OPEN, 2'd0, 1'b0, 1'b0);
    send_event(ACT_DONE, 2'd0, 1'b0, 1'b1);
    send_event(ACT_CLOSE, 2'd0, 1'b0, 1'b0);
    // reprobe, open and remove the card while the device wait is still pending
    send_event(ACT_INIT, MSTAT_UNMOUNTED, 1'b1, 1'b0);
    send_event(ACT_OPEN, 2'd0, 1'b0, 1'b0);
    send_event(ACT_REMOVED, 2'd0, 1'b0, 1'b0);
    send_event(ACT_RETRY, 2'd0, 1'b1, 1'b0);
    send_event(ACT_DONE, 2'd0, 1'b0, 1'b0);

    random_phase(8'd0, 120);
    random_phase(8'd1, 180);
    random_phase(8'd255, 200);
    random_phase(8'd3, 180);
    random_phase(8'd2, 160);
    random_phase(8'd7, 180);
    random_phase(RETRY_LIMIT_RESET, 200);
    random_phase(8'd1, 160);

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("[card_slot_mount_state_machine] OK");
    end else begin
      $display("[card_slot_mount_state_machine] ERROR");
    end
    $finish;
  end

endmodule
